// ===== sv/dq_pkg.sv =====
// Package with the types, codes and sizes shared by the double-ended queue.
package dq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ACT_PUSH_BACK  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_BACK,
    CELL_SHIFT_FRONT,
    CELL_PUSH_BACK,
    CELL_POP_BACK
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic signed [DATA_W-1:0] data;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] data_in;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [CNT_W-1:0]         occupancy;
    logic [1:0]               status;
  } out_t;

endpackage

// ===== sv/dq_cell.sv =====
// One storage cell of the queue row: holds one entry and trades it with its neighbors.
module dq_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dq_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [dq_pkg::DATA_W-1:0]  prev_data_i,
  input  logic                              prev_occ_i,
  input  logic signed [dq_pkg::DATA_W-1:0]  next_data_i,
  input  logic                              next_occ_i,
  output logic signed [dq_pkg::DATA_W-1:0]  data_o,
  output logic                              occ_o,
  output logic                              tail_o
);
  import dq_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     occ_q, occ_d;

  always_comb begin
    data_d = data_q;
    occ_d  = occ_q;
    case (ctrl_i.op)
      CELL_SHIFT_BACK: begin
        data_d = prev_data_i;
        occ_d  = prev_occ_i;
      end
      CELL_SHIFT_FRONT: begin
        data_d = next_data_i;
        occ_d  = next_occ_i;
      end
      CELL_PUSH_BACK: begin
        if (!occ_q && prev_occ_i) begin
          data_d = ctrl_i.data;
          occ_d  = 1'b1;
        end
      end
      CELL_POP_BACK: begin
        if (occ_q && !next_occ_i) begin
          occ_d = 1'b0;
        end
      end
      default: begin
        data_d = data_q;
        occ_d  = occ_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign occ_o  = occ_q;
  assign tail_o = occ_q && !next_occ_i;

endmodule

// ===== sv/double_ended_queue.sv =====
// Top level of the double-ended queue: control, row of cells and result register.
// A double-ended queue of CAPACITY signed 32-bit entries held in a row of cells, the
// front entry in the first cell. Each input transfer pushes or pops at either end and
// yields one result transfer (popped value, occupancy after the step, status). One
// item is taken every clock cycle; its result appears in the cycle after the input
// transfer, from the output register, and the input stays ready while that register
// is empty or being drained. Pushes at the front and pops at the front shift every
// cell of the row by one place in the same cycle; the back entry is found through the
// occupied flags of the cells and read through a one-hot select over the row.
module double_ended_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  dq_pkg::in_t  in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output dq_pkg::out_t out_data_o
);
  import dq_pkg::*;

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_occ;
  logic [CAPACITY-1:0]      cell_tail;
  logic signed [DATA_W-1:0] back_sel  [CAPACITY];

  cell_ctrl_t       ctrl;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  out_t             out_q, out_d;
  logic             out_valid_q;
  logic             accept;
  logic             full;
  logic             empty;
  logic signed [DATA_W-1:0] back_data;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (cnt_q == CNT_W'(CAPACITY));
  assign empty      = (cnt_q == '0);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_data, next_data;
    logic                     prev_occ, next_occ;

    if (i == 0) begin : g_first
      assign prev_data = ctrl.data;
      assign prev_occ  = 1'b1;
    end else begin : g_mid
      assign prev_data = cell_data[i-1];
      assign prev_occ  = cell_occ[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_data = '0;
      assign next_occ  = 1'b0;
    end else begin : g_inner
      assign next_data = cell_data[i+1];
      assign next_occ  = cell_occ[i+1];
    end

    dq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_data_i (prev_data),
      .prev_occ_i  (prev_occ),
      .next_data_i (next_data),
      .next_occ_i  (next_occ),
      .data_o      (cell_data[i]),
      .occ_o       (cell_occ[i]),
      .tail_o      (cell_tail[i])
    );

    if (i == 0) begin : g_sel0
      assign back_sel[i] = cell_tail[i] ? cell_data[i] : '0;
    end else begin : g_seln
      assign back_sel[i] = back_sel[i-1] | (cell_tail[i] ? cell_data[i] : '0);
    end
  end

  assign back_data = back_sel[CAPACITY-1];

  always_comb begin
    ctrl.op            = CELL_HOLD;
    ctrl.data          = in_data_i.data_in;
    cnt_d              = cnt_q;
    out_d.data_out     = '0;
    out_d.occupancy    = cnt_q;
    out_d.status       = ST_OK;
    if (accept) begin
      case (action_e'(in_data_i.action))
        ACT_PUSH_BACK: begin
          if (full) begin
            out_d.status = ST_FULL;
          end else begin
            ctrl.op = CELL_PUSH_BACK;
            cnt_d   = cnt_q + CNT_W'(1);
          end
        end
        ACT_PUSH_FRONT: begin
          if (full) begin
            out_d.status = ST_FULL;
          end else begin
            ctrl.op = CELL_SHIFT_BACK;
            cnt_d   = cnt_q + CNT_W'(1);
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            out_d.status = ST_EMPTY;
          end else begin
            ctrl.op        = CELL_SHIFT_FRONT;
            out_d.data_out = cell_data[0];
            cnt_d          = cnt_q - CNT_W'(1);
          end
        end
        ACT_POP_BACK: begin
          if (empty) begin
            out_d.status = ST_EMPTY;
          end else begin
            ctrl.op        = CELL_POP_BACK;
            out_d.data_out = back_data;
            cnt_d          = cnt_q - CNT_W'(1);
          end
        end
        default: begin
          ctrl.op = CELL_HOLD;
        end
      endcase
    end
    out_d.occupancy = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/dq_checker.sv =====
// Port-level checker for the double-ended queue, bound to the top level.
module dq_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_ready_o,
  input logic         out_valid_o,
  input logic         out_ready_i,
  input dq_pkg::out_t out_data_o
);
  import dq_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |->
      out_data_o.occupancy == CNT_W'(CAPACITY) && out_data_o.data_out == '0)
    else $error("full push result malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY |->
      out_data_o.occupancy == '0 && out_data_o.data_out == '0)
    else $error("empty pop result malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.occupancy <= CNT_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("transfer gave no result");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== sim/double_ended_queue_tb.sv =====
// Self-checking testbench for double_ended_queue: directed, then random push/pop traffic against a deque model.
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import dq_pkg::*;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_e;

  class deque_tracker;
    logic signed [DATA_W-1:0] slots [CAPACITY];
    int unsigned              head;
    int unsigned              fill;
    out_t                     pending_results [$];
    int unsigned              errors;

    function new();
      head   = 0;
      fill   = 0;
      errors = 0;
    endfunction

    function int unsigned pending_count();
      return pending_results.size();
    endfunction

    function void note_request(in_t item);
      out_t res;
      res        = '0;
      res.status = ST_OK;
      case (item.action)
        ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
          if (fill >= CAPACITY) begin
            res.status = ST_FULL;
          end else if (item.action == ACT_PUSH_BACK) begin
            slots[(head + fill) % CAPACITY] = item.data_in;
            fill++;
          end else begin
            head        = (head + CAPACITY - 1) % CAPACITY;
            slots[head] = item.data_in;
            fill++;
          end
        end
        default: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
          end else if (item.action == ACT_POP_FRONT) begin
            res.data_out = slots[head];
            head         = (head + 1) % CAPACITY;
            fill--;
          end else begin
            res.data_out = slots[(head + fill - 1) % CAPACITY];
            fill--;
          end
        end
      endcase
      res.occupancy = CNT_W'(fill);
      pending_results.push_back(res);
    endfunction

    function void check_response(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected transfer: data_out %0d occupancy %0d status %0d",
               got.data_out, got.occupancy, got.status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.data_out !== want.data_out) begin
        $error("data_out: expected %0d, got %0d", want.data_out, got.data_out);
        errors++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i          = 1'b0;
  logic rst_ni         = 1'b0;
  logic in_valid       = 1'b0;
  logic in_ready_o;
  in_t  in_data        = '0;
  logic out_valid_o;
  logic out_ready      = 1'b0;
  out_t out_data_o;

  bit sender_burst   = 1'b1;
  bit receiver_burst = 1'b0;

  deque_tracker tracker;

  double_ended_queue u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) tracker.note_request(in_data);
      if (out_valid_o && out_ready) tracker.check_response(out_data_o);
    end
  end

  function automatic action_e pick_action(mix_e mix);
    int unsigned roll;
    bit          push;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  push = (roll < 80);
      MIX_DRAIN: push = (roll < 20);
      default:   push = (roll < 50);
    endcase
    if (push) return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
    return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input action_e act, input logic signed [DATA_W-1:0] value);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= in_t'{action: act, data_in: value};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_count() != 0);
  endtask

  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = receiver_burst ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int unsigned sent;
    int unsigned span;
    mix_e        mix;
    tracker = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ACT_POP_FRONT, 32'h1234_5678);
    send_item(ACT_POP_BACK, 32'hffff_ffff);
    send_item(ACT_PUSH_BACK, 32'h7fff_ffff);
    send_item(ACT_PUSH_FRONT, 32'h8000_0000);
    send_item(ACT_PUSH_BACK, 32'h0000_0000);
    send_item(ACT_PUSH_BACK, 32'hffff_ffff);
    send_item(ACT_POP_FRONT, 32'h0);
    send_item(ACT_POP_BACK, 32'h0);
    send_item(ACT_POP_BACK, 32'h0);
    send_item(ACT_POP_FRONT, 32'h0);
    send_item(ACT_PUSH_FRONT, 32'h5555_5555);
    send_item(ACT_PUSH_FRONT, 32'haaaa_aaaa);
    send_item(ACT_POP_BACK, 32'h0);
    send_item(ACT_POP_BACK, 32'h0);
    send_item(ACT_POP_BACK, 32'h0);
    wait_drained();

    sent = 0;
    while (sent < 1400) begin
      span           = $urandom_range(40, 100);
      mix            = mix_e'($urandom_range(0, 2));
      sender_burst   = ($urandom_range(0, 3) == 0);
      receiver_burst = ($urandom_range(0, 3) == 0);
      repeat (span) send_item(pick_action(mix), pick_value());
      sent += span;
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
